// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the record sorter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RSBK_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the default clk_i / rst_ni pair.
`define RSBK_ASSERT(lbl, prop, msg) `RSBK_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/rsbk_pkg.sv -----
// Shared constants, record type, controller states and datapath commands
// of the record sorter. No dependencies.
package rsbk_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_BITS  = 32;

  localparam int KEY_W  = 32;
  localparam int TAG_W  = 8;
  localparam int DATA_W = KEY_W + TAG_W;
  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
                                          KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_RD_FIRST,
    ST_CARRY,
    ST_CMP,
    ST_PASS_END,
    ST_OUT_RD,
    ST_OUT_LD
  } st_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_SORT_INIT,
    OP_RD_FIRST,
    OP_CARRY_LD,
    OP_CMP,
    OP_PASS_END,
    OP_OUT_RD,
    OP_OUT_LD
  } dp_op_e;

  typedef struct packed {
    logic limit_zero;
    logic j_at_limit;
    logic k_at_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/rsbk_datapath.sv -----
// Record store, bubble-pass compare unit, counters and output register.
// Depends on rsbk_pkg; driven by rsbk_ctrl through dp_op_e commands.
module rsbk_datapath import rsbk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_op_e            op_i,
  output sts_t              sts_o,
  input  logic [DATA_W-1:0] s_tdata_i,   // [31:0] key_in, [39:32] tag_in
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o,   // [31:0] key_out, [39:32] tag_out
  output logic              m_tlast_o,
  output logic              m_tuser_o    // [0] dropped
);

  rec_t             mem [MAX_ITEMS];
  rec_t             rd_q;
  rec_t             carry_q, carry_d;
  rec_t             out_rec_q;
  logic             out_last_q, out_drop_q;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] j_q, j_d, limit_q, limit_d, k_q, k_d;

  rec_t             in_rec;
  rec_t             wr_data;
  logic             wr_en, rd_en, carry_ld, full, swap, k_last;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  // Unpack the incoming record and mask the key
  assign in_rec.key = s_tdata_i[KEY_W-1:0] & KEY_MASK;
  assign in_rec.tag = s_tdata_i[KEY_W +: TAG_W];

  assign full   = (fill_q == CNT_W'(MAX_ITEMS));
  // Strict compare keeps equal keys in arrival order
  assign swap   = (carry_q.key > rd_q.key);
  assign k_last = ((CNT_W'(k_q) + CNT_W'(1)) == fill_q);

  // Decode the command into memory, counter and carry controls
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = in_rec;
    rd_en    = 1'b0;
    rd_addr  = '0;
    carry_ld = 1'b0;
    carry_d  = rd_q;
    fill_d   = fill_q;
    ovf_d    = ovf_q;
    j_d      = j_q;
    limit_d  = limit_q;
    k_d      = k_q;
    case (op_i)
      OP_STORE: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = fill_q[IDX_W-1:0];
          wr_data = in_rec;
          fill_d  = fill_q + CNT_W'(1);
        end
      end
      OP_SORT_INIT: begin
        limit_d = IDX_W'(fill_q - CNT_W'(1));
        k_d     = '0;
      end
      OP_RD_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        j_d     = IDX_W'(1);
      end
      OP_CARRY_LD: begin
        carry_ld = 1'b1;
        carry_d  = rd_q;
        rd_en    = 1'b1;
        rd_addr  = j_q;
      end
      OP_CMP: begin
        // Write back the smaller of carry and element j one place down
        wr_en   = 1'b1;
        wr_addr = j_q - IDX_W'(1);
        if (swap) begin
          wr_data = rd_q;
        end else begin
          wr_data  = carry_q;
          carry_ld = 1'b1;
          carry_d  = rd_q;
        end
        rd_en   = 1'b1;
        rd_addr = j_q + IDX_W'(1);
        j_d     = j_q + IDX_W'(1);
      end
      OP_PASS_END: begin
        wr_en   = 1'b1;
        wr_addr = limit_q;
        wr_data = carry_q;
        limit_d = limit_q - IDX_W'(1);
      end
      OP_OUT_RD: begin
        rd_en   = 1'b1;
        rd_addr = k_q;
      end
      OP_OUT_LD: begin
        if (k_last) begin
          fill_d = '0;
          ovf_d  = 1'b0;
          k_d    = '0;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: clear on transaction, set on load
  always_comb begin
    out_valid_d = out_valid_q & ~m_tready_i;
    if (op_i == OP_OUT_LD) begin
      out_valid_d = 1'b1;
    end
  end

  // Record store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (carry_ld) begin
      carry_q <= carry_d;
    end
    if (op_i == OP_OUT_LD) begin
      out_rec_q  <= rd_q;
      out_last_q <= k_last;
      out_drop_q <= ovf_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      j_q         <= '0;
      limit_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      j_q         <= j_d;
      limit_q     <= limit_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.limit_zero = (limit_q == '0);
  assign sts_o.j_at_limit = (j_q == limit_q);
  assign sts_o.k_at_last  = k_last;
  assign sts_o.out_free   = ~out_valid_q | m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_rec_q.tag, out_rec_q.key};
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_drop_q;

endmodule

// ----- rtl/rsbk_ctrl.sv -----
// Controller state machine of the record sorter: load, bubble passes, drain.
// Depends on rsbk_pkg; commands rsbk_datapath.
module rsbk_ctrl import rsbk_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   s_tvalid_i,
  input  logic   s_tlast_i,
  output logic   s_tready_o,
  input  sts_t   sts_i,
  output dp_op_e op_o
);

  st_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (s_tvalid_i && s_tlast_i) begin
          state_d = ST_SORT_INIT;
        end
      end
      ST_SORT_INIT: state_d = ST_RD_FIRST;
      ST_RD_FIRST: begin
        state_d = sts_i.limit_zero ? ST_OUT_RD : ST_CARRY;
      end
      ST_CARRY: state_d = ST_CMP;
      ST_CMP: begin
        if (sts_i.j_at_limit) begin
          state_d = ST_PASS_END;
        end
      end
      ST_PASS_END: state_d = ST_RD_FIRST;
      ST_OUT_RD:   state_d = ST_OUT_LD;
      ST_OUT_LD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.k_at_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    op_o       = OP_NONE;
    s_tready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_tready_o = 1'b1;
        op_o       = s_tvalid_i ? OP_STORE : OP_NONE;
      end
      ST_SORT_INIT: op_o = OP_SORT_INIT;
      ST_RD_FIRST:  op_o = sts_i.limit_zero ? OP_NONE : OP_RD_FIRST;
      ST_CARRY:     op_o = OP_CARRY_LD;
      ST_CMP:       op_o = OP_CMP;
      ST_PASS_END:  op_o = OP_PASS_END;
      ST_OUT_RD:    op_o = OP_OUT_RD;
      ST_OUT_LD:    op_o = sts_i.out_free ? OP_OUT_LD : OP_NONE;
      default:      op_o = OP_NONE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/record_sorter_by_key_top.sv -----
// Top level of the record sorter: controller plus datapath.
// Depends on rsbk_pkg, rsbk_ctrl and rsbk_datapath.
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid / s_tready | tdata {tag_in, key_in}, tlast last_in
//  m_*     | out | m_tvalid / m_tready | tdata {tag_out, key_out}, tlast, tuser dropped
//
// Loading takes a record whenever s_tvalid is high. After the record marked
// last, the records are sorted in bubble passes, each streaming the store once,
// one compare per cycle, after read-first and carry-load steps and before a
// pass-end step. In the drain the next result is read while the previous one
// waits in the output register. Reset clears the fill count and the controller;
// the store needs no clearing. A stalled output holds the whole drain; input is
// taken again once the final result sits in the output register.
module record_sorter_by_key_top import rsbk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [DATA_W-1:0] s_tdata_i,   // [31:0] key_in, [39:32] tag_in
  input  logic              s_tlast_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o,   // [31:0] key_out, [39:32] tag_out
  output logic              m_tlast_o,
  output logic              m_tuser_o    // [0] dropped
);

  dp_op_e op;
  sts_t   sts;

  rsbk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tlast_i  (s_tlast_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  rsbk_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .sts_o      (sts),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

// ----- rtl/rsbk_checker.sv -----
// Port-level checker for the record sorter, bound to the top level.
// Depends on rsbk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsbk_checker import rsbk_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_tvalid_i,
  input logic              s_tready_o,
  input logic [DATA_W-1:0] s_tdata_i,
  input logic              s_tlast_i,
  input logic              m_tvalid_o,
  input logic              m_tready_i,
  input logic [DATA_W-1:0] m_tdata_o,
  input logic              m_tlast_o,
  input logic              m_tuser_o
);

  logic             in_run_q;
  logic [KEY_W-1:0] prev_key_q;
  logic             prev_user_q;
  logic             m_xfer, s_end;

  assign m_xfer = m_tvalid_o & m_tready_i;
  assign s_end  = s_tvalid_i & s_tready_o & s_tlast_i;

  // Track the previous result of the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q    <= 1'b0;
      prev_key_q  <= '0;
      prev_user_q <= 1'b0;
    end else if (m_xfer) begin
      in_run_q    <= ~m_tlast_o;
      prev_key_q  <= m_tdata_o[KEY_W-1:0];
      prev_user_q <= m_tuser_o;
    end
  end

  `RSBK_ASSERT(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o, "result dropped while stalled")
  `RSBK_ASSERT(a_stop_after_last, s_end |=> !s_tready_o, "input taken during sort")
  `RSBK_ASSERT(a_sorted, m_xfer && in_run_q |-> m_tdata_o[KEY_W-1:0] >= prev_key_q, "keys out of order")
  `RSBK_ASSERT(a_drop_flag, m_xfer && in_run_q |-> m_tuser_o == prev_user_q, "dropped flag changed in run")

endmodule

bind record_sorter_by_key_top rsbk_checker u_rsbk_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for record_sorter_by_key_top: loads record sets, predicts
// the stable ascending sort of each set and checks every emitted record.
// Depends on rsbk_pkg and the record sorter RTL.
`timescale 1ns / 100ps

module testbench;
  import rsbk_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 600;

  // One expected output transaction
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             dropped;
  } sorted_rec_t;

  // Flavors of key content for one set
  typedef enum int {
    KEYS_WIDE,
    KEYS_CROWDED,
    KEYS_EDGY
  } key_mix_e;

  // Holds the current set, sorts it on the last record, checks the drain
  class sort_order_check;
    rec_t        held[MAX_ITEMS];
    int unsigned fill;
    bit          overflow;
    sorted_rec_t due[$];
    int unsigned errors;

    function new();
      fill     = 0;
      overflow = 0;
      errors   = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Store one accepted record; on the last one, sort stably and queue the run
    function void note_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                              logic last);
      rec_t        r;
      sorted_rec_t s;
      int          i;
      int          j;
      if (fill < MAX_ITEMS) begin
        held[fill].key = key & KEY_MASK;
        held[fill].tag = tag;
        fill++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;
      // Insertion sort: strict compare keeps equal keys in arrival order
      for (i = 1; i < fill; i++) begin
        r = held[i];
        j = i;
        while (j > 0 && held[j-1].key > r.key) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = r;
      end
      for (i = 0; i < fill; i++) begin
        s.key     = held[i].key;
        s.tag     = held[i].tag;
        s.last    = (i == fill - 1);
        s.dropped = overflow;
        due.push_back(s);
      end
      fill     = 0;
      overflow = 1'b0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one output transaction against the oldest expectation
    task check_output(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last,
                      logic dropped);
      sorted_rec_t exp;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected record key=%h tag=%h", key, tag));
        return;
      end
      exp = due.pop_front();
      if (key !== exp.key)
        report_mismatch($sformatf("key %h, expected %h", key, exp.key));
      if (tag !== exp.tag)
        report_mismatch($sformatf("tag %h, expected %h", tag, exp.tag));
      if (last !== exp.last)
        report_mismatch($sformatf("tlast %b, expected %b", last, exp.last));
      if (dropped !== exp.dropped)
        report_mismatch($sformatf("dropped %b, expected %b", dropped, exp.dropped));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_tvalid_i;
  logic              s_tready_o;
  logic [DATA_W-1:0] s_tdata_i;   // [31:0] key_in, [39:32] tag_in
  logic              s_tlast_i;
  logic              m_tvalid_o;
  logic              m_tready_i;
  logic [DATA_W-1:0] m_tdata_o;   // [31:0] key_out, [39:32] tag_out
  logic              m_tlast_o;
  logic              m_tuser_o;   // [0] dropped

  sort_order_check order_check = new();
  bit              idle_en     = 1'b1;
  int              hold_cycles = 0;
  int              records_sent = 0;
  int              cycle_count = 0;

  record_sorter_by_key_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: a long hold-off while hold_cycles runs, else random stall bursts while idle_en is set
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_tready_i = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        m_tready_i = 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        m_tready_i = 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        m_tready_i = 1'b1;
      end
    end
  end

  // Check every output transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i)
      order_check.check_output(m_tdata_o[KEY_W-1:0], m_tdata_o[DATA_W-1:KEY_W],
                               m_tlast_o, m_tuser_o);
  end

  // Offer one record and hold it until the input transaction completes
  task send_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i  = {tag, key};
    s_tlast_i  = last;
    do @(posedge clk_i); while (!s_tready_o);
    order_check.note_record(key, tag, last);
    records_sent++;
  endtask

  // Drop valid and wait for the whole expected drain
  task pause_until_drained();
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    while (order_check.pending() > 0) @(posedge clk_i);
  endtask

  // Send one set of random records, the final one marked last
  task send_set(int count);
    key_mix_e         mix;
    logic [KEY_W-1:0] key;
    mix = key_mix_e'($urandom_range(0, 2));
    for (int i = 0; i < count; i++) begin
      case (mix)
        KEYS_WIDE:    key = $urandom();
        KEYS_CROWDED: key = $urandom_range(0, 3);
        default:      key = $urandom_range(0, 1) ? '1 : $urandom_range(0, 1) ? '0 : $urandom();
      endcase
      send_record(key, TAG_W'($urandom_range(0, 255)), i == count - 1);
    end
  endtask

  task send_random_set();
    send_set($urandom_range(0, 9) == 0 ? $urandom_range(11, MAX_ITEMS)
                                       : $urandom_range(1, 10));
  endtask

  initial begin
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    s_tlast_i  = 1'b0;
    rst_ni     = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Single-record sets at both key and tag extremes
    send_record('1, 8'hFF, 1'b1);
    send_record('0, 8'h00, 1'b1);
    // Reverse order across the unsigned key range
    send_record(32'hFFFF_FFFF, 8'd0, 1'b0);
    send_record(32'h8000_0000, 8'd1, 1'b0);
    send_record(32'h0001_0000, 8'd2, 1'b0);
    send_record(32'h0000_FFFF, 8'd3, 1'b0);
    send_record(32'h0000_0001, 8'd4, 1'b0);
    send_record(32'h0000_0000, 8'd5, 1'b1);
    // Equal keys must keep arrival order
    send_record(32'd7, 8'hA0, 1'b0);
    send_record(32'd3, 8'hA1, 1'b0);
    send_record(32'd7, 8'hA2, 1'b0);
    send_record(32'd3, 8'hA3, 1'b0);
    send_record(32'd7, 8'hA4, 1'b1);
    send_record(32'h5555_5555, 8'h55, 1'b0);
    send_record(32'h5555_5555, 8'hAA, 1'b1);
    // Already sorted
    send_record(32'h0000_0010, 8'h10, 1'b0);
    send_record(32'h0000_0020, 8'h20, 1'b0);
    send_record(32'h0000_0030, 8'h30, 1'b0);
    send_record(32'h0000_0040, 8'h40, 1'b1);
    pause_until_drained();

    records_sent = 0;
    while (records_sent < 25) send_random_set();
    pause_until_drained();

    // Block the output while sets keep arriving, so the input backs up
    @(posedge clk_i);
    hold_cycles = HOLD_CYCLES;
    repeat (3) send_set(4);

    // Overflow: full store, then dropped records including the last one
    send_set(MAX_ITEMS + 2);

    while (records_sent < 110) send_random_set();
    pause_until_drained();

    // Final stretch at full rate on both sides
    idle_en = 1'b0;
    repeat (5) send_set($urandom_range(1, 8));
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (order_check.errors == 0 && order_check.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- record_sorter_by_key_top.f -----
+incdir+rtl
rtl/rsbk_pkg.sv
rtl/rsbk_datapath.sv
rtl/rsbk_ctrl.sv
rtl/record_sorter_by_key_top.sv
rtl/rsbk_checker.sv
dv/testbench.sv
